// File: rtl/leg_inverse_kinematics_macros.svh
// Assertion macros shared by the leg inverse kinematics RTL.
`ifndef LEG_INVERSE_KINEMATICS_MACROS_SVH
`define LEG_INVERSE_KINEMATICS_MACROS_SVH

// Asserts that prop holds at every clock edge outside reset.
`define LIK_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Asserts that cond implies prop at the following clock edge.
`define LIK_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: rtl/lik_pkg.sv
// ---------------------------------------------------------------------------
// Leg inverse kinematics package
// Shared widths, CORDIC constants and register indexes.
// ---------------------------------------------------------------------------
package lik_pkg;
	localparam int CoordW = 24;
	localparam int LenW = 20;
	localparam int AngW = 16;
	localparam int CfgIdxW = 2;
	localparam int CordicSteps = 17;
	localparam int CordicW = 33;
	localparam int AccW = 20;
	localparam int SqrtInW = 64;
	// Each of the two square-root lanes carries half of the shared side data.
	localparam int SqrtTagW = 83;

	localparam logic [CfgIdxW-1:0] REG_HIP_OFFSET = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_UPPER_LINK = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_LOWER_LINK = 2'd2;

	localparam logic signed [AccW-1:0] PI_Q16 = 20'sd205887;

	typedef logic signed [CordicW-1:0] cvec_t;
	typedef logic signed [AccW-1:0] acc_t;

	function automatic acc_t atan_entry(input int i);
		acc_t v;
		case (i)
			0: v = 20'sd51472;
			1: v = 20'sd30386;
			2: v = 20'sd16055;
			3: v = 20'sd8150;
			4: v = 20'sd4091;
			5: v = 20'sd2047;
			6: v = 20'sd1024;
			7: v = 20'sd512;
			8: v = 20'sd256;
			9: v = 20'sd128;
			10: v = 20'sd64;
			11: v = 20'sd32;
			12: v = 20'sd16;
			13: v = 20'sd8;
			14: v = 20'sd4;
			15: v = 20'sd2;
			16: v = 20'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage

// File: rtl/lik_isqrt.sv
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Bitwise restoring square root, one result bit per stage, valid travels along.
// ---------------------------------------------------------------------------
module lik_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [lik_pkg::SqrtInW-1:0]   in_value,
	input  logic [lik_pkg::SqrtTagW-1:0]  in_tag,
	output logic                          out_valid,
	output logic [lik_pkg::SqrtInW/2-1:0] out_root,
	output logic [lik_pkg::SqrtTagW-1:0]  out_tag
);
	import lik_pkg::*;

	localparam int Steps = SqrtInW / 2;

	logic [Steps:0]          vld_s;
	logic [SqrtInW-1:0]      rem_s [Steps+1];
	logic [Steps-1:0]        root_s [Steps+1];
	logic [SqrtTagW-1:0]     tag_s [Steps+1];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = in_value;
	assign root_s[0] = '0;
	assign tag_s[0] = in_tag;

	for (genvar k = 0; k < Steps; k++) begin : g_step
		localparam int Sh = 2 * (Steps - 1 - k);
		logic [SqrtInW-1:0] trial;
		logic [SqrtInW-1:0] part;
		logic               take;
		assign part = rem_s[k] >> Sh;
		assign trial = {root_s[k], 2'b01};
		assign take = part >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			tag_s[k+1] <= tag_s[k];
			root_s[k+1] <= {root_s[k][Steps-2:0], take};
			if (take) begin
				rem_s[k+1] <= rem_s[k] - (trial << Sh);
			end else begin
				rem_s[k+1] <= rem_s[k];
			end
		end
	end

	assign out_valid = vld_s[Steps];
	assign out_root = root_s[Steps];
	assign out_tag = tag_s[Steps];
endmodule

// File: rtl/lik_cordic.sv
// ---------------------------------------------------------------------------
// Pipelined CORDIC vectoring unit
// Quadrant fold, normalization shift, then one micro-rotation per stage.
// ---------------------------------------------------------------------------
`include "leg_inverse_kinematics_macros.svh"
module lik_cordic (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic signed [95:0] in_y,
	input  logic signed [95:0] in_x,
	output logic          out_valid,
	output lik_pkg::acc_t out_angle
);
	import lik_pkg::*;

	localparam cvec_t NegLimit = -33'sh20000000;

	// Stage 1: fold to the right half plane and find the magnitude.
	logic signed [96:0] fx, fy;
	logic [96:0] mx, my, mm;
	logic zero_in;
	assign zero_in = (in_x == '0) && (in_y == '0);
	assign fx = in_x[95] ? -97'(in_x) : 97'(in_x);
	assign fy = in_x[95] ? -97'(in_y) : 97'(in_y);
	assign mx = fx[96] ? 97'(-fx) : 97'(fx);
	assign my = fy[96] ? 97'(-fy) : 97'(fy);
	assign mm = (mx > my) ? mx : my;

	logic              vld_s1, zero_s1;
	logic signed [96:0] x_s1, y_s1;
	logic [96:0]       m_s1;
	acc_t              acc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		x_s1 <= fx;
		y_s1 <= fy;
		m_s1 <= mm;
		zero_s1 <= zero_in;
		if (in_x[95]) begin
			acc_s1 <= in_y[95] ? -PI_Q16 : PI_Q16;
		end else begin
			acc_s1 <= '0;
		end
	end

	// Stage 2: leading one position sets the shift so that 2^28 <= m < 2^29.
	logic [6:0] lead;
	always_comb begin
		lead = '0;
		for (int b = 0; b < 97; b++) begin
			if (m_s1[b]) begin
				lead = 7'(b);
			end
		end
	end

	logic              vld_s2, zero_s2, left_s2;
	logic [6:0]        amt_s2;
	logic signed [96:0] x_s2, y_s2;
	acc_t              acc_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		x_s2 <= x_s1;
		y_s2 <= y_s1;
		acc_s2 <= acc_s1;
		zero_s2 <= zero_s1;
		left_s2 <= lead < 7'd28;
		amt_s2 <= (lead < 7'd28) ? 7'd28 - lead : lead - 7'd28;
	end

	// Stage 3: apply the shift. Repeated floor halving equals one arithmetic shift.
	// A negative y grows in magnitude under floor halving and can land exactly on
	// -2^29; one more halving then brings both operands into range.
	cvec_t xn_c, yn_c;
	assign xn_c = left_s2 ? CordicW'(x_s2 <<< amt_s2) : CordicW'(x_s2 >>> amt_s2);
	assign yn_c = left_s2 ? CordicW'(y_s2 <<< amt_s2) : CordicW'(y_s2 >>> amt_s2);

	logic              vld_s3, zero_s3;
	cvec_t             x_s3, y_s3;
	acc_t              acc_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end
	always_ff @(posedge clk) begin
		acc_s3 <= acc_s2;
		zero_s3 <= zero_s2;
		if (yn_c == NegLimit) begin
			x_s3 <= xn_c >>> 1;
			y_s3 <= yn_c >>> 1;
		end else begin
			x_s3 <= xn_c;
			y_s3 <= yn_c;
		end
	end

	// Micro-rotation stages.
	logic [CordicSteps:0] vld_r;
	logic [CordicSteps:0] zero_r;
	cvec_t               x_r [CordicSteps+1];
	cvec_t               y_r [CordicSteps+1];
	acc_t                acc_r [CordicSteps+1];

	assign vld_r[0] = vld_s3;
	assign zero_r[0] = zero_s3;
	assign x_r[0] = x_s3;
	assign y_r[0] = y_s3;
	assign acc_r[0] = acc_s3;

	for (genvar i = 0; i < CordicSteps; i++) begin : g_rot
		cvec_t xs, ys;
		assign xs = x_r[i] >>> i;
		assign ys = y_r[i] >>> i;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_r[i+1] <= 1'b0;
			end else begin
				vld_r[i+1] <= vld_r[i];
			end
		end
		always_ff @(posedge clk) begin
			zero_r[i+1] <= zero_r[i];
			if (y_r[i] > 0) begin
				x_r[i+1] <= x_r[i] + ys;
				y_r[i+1] <= y_r[i] - xs;
				acc_r[i+1] <= acc_r[i] + atan_entry(i);
			end else begin
				x_r[i+1] <= x_r[i] - ys;
				y_r[i+1] <= y_r[i] + xs;
				acc_r[i+1] <= acc_r[i] - atan_entry(i);
			end
		end
	end

	assign out_valid = vld_r[CordicSteps];
	assign out_angle = zero_r[CordicSteps] ? '0 : acc_r[CordicSteps];

	`LIK_ASSERT_NEXT(a_norm_range, clk, arst_n, vld_s2 && !zero_s2,
		(x_s3 >= 0) && (x_s3 < 33'sh40000000), "cordic x out of range after normalize")
	`LIK_ASSERT_NEXT(a_valid_flow, clk, arst_n, in_valid, vld_s1, "cordic valid lost")
	`LIK_ASSERT(a_acc_bound, clk, arst_n,
		!vld_r[CordicSteps] || (out_angle <= 20'sd411774 && out_angle >= -20'sd411774),
		"cordic angle out of range")
endmodule

// File: rtl/leg_inverse_kinematics.sv
// ---------------------------------------------------------------------------
// Leg inverse kinematics
// Hip, thigh and knee angles of a three-joint leg from a foot target.
// ---------------------------------------------------------------------------
// Usage: pulse start with target_x/y/z; a transaction is taken when start is
// high and busy is low. busy is always low, so one target can be taken every
// clock cycle. Each target gives exactly one result, shown for one cycle with
// done high, in order; the receiver cannot stall the block.
// The path to done has 86 register stages: two front stages (squares, sums
// and the reachability test), a 30-stage pipelined restoring divider for D,
// a 32-stage pipelined square root for r and for sin Q3, one product stage,
// the CORDIC units (three setup stages and 17 rotation stages) and an output
// register. Throughput is one target per cycle, set by the fully pipelined
// units.
// Configuration: cfg_we, cfg_index, cfg_data write one link length register
// per cycle; write only while no transaction is in flight.
// Reset clears all valid bits and loads the register reset values.
// Unreachable targets give reachable low and zero angles.
// ---------------------------------------------------------------------------
`include "leg_inverse_kinematics_macros.svh"
module leg_inverse_kinematics (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [23:0]           target_x,
	input  logic signed [23:0]           target_y,
	input  logic signed [23:0]           target_z,
	input  logic                         cfg_we,
	input  logic [lik_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [lik_pkg::LenW-1:0]     cfg_data,
	output logic                         done,
	output logic signed [15:0]           hip_angle,
	output logic signed [15:0]           thigh_angle,
	output logic signed [15:0]           knee_angle,
	output logic                         reachable
);
	import lik_pkg::*;

	// Total pipeline depth from the registers of stage 1 to done: 86 stages.
	// 2 front + 30 divide + 32 root + 1 product + 20 cordic + 1 output.
	localparam int DivSteps = 30;
	localparam int SqW = 62;

	logic [LenW-1:0] l1_q, l2_q, l3_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q <= '0;
			l2_q <= 20'd256;
			l3_q <= 20'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HIP_OFFSET: l1_q <= cfg_data;
				REG_UPPER_LINK: l2_q <= cfg_data;
				REG_LOWER_LINK: l3_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;
	logic acc_in;
	assign acc_in = start && !busy;

	// Stage 1: squares of the target coordinates (24x24) and link length products (20x20).
	logic vld_s1;
	logic signed [23:0] x_s1, y_s1, z_s1;
	logic [47:0] xx_s1, yy_s1, zz_s1;
	logic [39:0] l1l1_s1, l2l2_s1, l3l3_s1, l2l3_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= acc_in;
	end
	always_ff @(posedge clk) begin
		x_s1 <= target_x;
		y_s1 <= target_y;
		z_s1 <= target_z;
		xx_s1 <= 48'(target_x * target_x);
		yy_s1 <= 48'(target_y * target_y);
		zz_s1 <= 48'(target_z * target_z);
		l1l1_s1 <= l1_q * l1_q;
		l2l2_s1 <= l2_q * l2_q;
		l3l3_s1 <= l3_q * l3_q;
		l2l3_s1 <= l2_q * l3_q;
	end

	// Stage 2: s, n, den and the reachability test.
	logic signed [51:0] s_c, n_c;
	logic [51:0] an_c;
	logic [41:0] den_c;
	assign s_c = 52'(xx_s1) + 52'(yy_s1) - 52'(l1l1_s1);
	assign n_c = s_c + 52'(zz_s1) - 52'(l2l2_s1) - 52'(l3l3_s1);
	assign an_c = n_c[51] ? 52'(-n_c) : 52'(n_c);
	assign den_c = {l2l3_s1, 1'b0};

	logic vld_s2, ok_s2, nneg_s2;
	logic signed [23:0] x_s2, y_s2, z_s2;
	logic [49:0] s_s2;
	logic [41:0] an_s2, den_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		x_s2 <= x_s1;
		y_s2 <= y_s1;
		z_s2 <= z_s1;
		s_s2 <= s_c[49:0];
		an_s2 <= an_c[41:0];
		den_s2 <= den_c;
		nneg_s2 <= n_c[51];
		ok_s2 <= !s_c[51] && (den_c != '0) && (an_c <= 52'(den_c));
	end

	// Divide: q = an/den (0 or 1 since an <= den), then 30 fraction bits.
	localparam int DTagW = 1 + 1 + 24*3 + LenW*3;
	logic [DivSteps:0] dv_v;
	logic [42:0] dv_rem [DivSteps+1];
	logic [41:0] dv_den [DivSteps+1];
	logic [DivSteps:0] dv_q [DivSteps+1];
	logic [49:0] dv_s [DivSteps+1];
	logic [DTagW-1:0] dv_tag [DivSteps+1];

	assign dv_v[0] = vld_s2;
	assign dv_rem[0] = (an_s2 == den_s2) ? '0 : 43'(an_s2);
	assign dv_den[0] = den_s2;
	assign dv_q[0] = 31'(an_s2 == den_s2);
	assign dv_s[0] = s_s2;
	assign dv_tag[0] = {ok_s2, nneg_s2, x_s2, y_s2, z_s2, l1_q, l2_q, l3_q};

	for (genvar k = 0; k < DivSteps; k++) begin : g_div
		logic [42:0] r2;
		logic ge;
		assign r2 = {dv_rem[k][41:0], 1'b0};
		assign ge = r2 >= 43'(dv_den[k]);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[k+1] <= 1'b0;
			else dv_v[k+1] <= dv_v[k];
		end
		always_ff @(posedge clk) begin
			dv_den[k+1] <= dv_den[k];
			dv_s[k+1] <= dv_s[k];
			dv_tag[k+1] <= dv_tag[k];
			dv_q[k+1] <= {dv_q[k][DivSteps-1:0], ge};
			dv_rem[k+1] <= ge ? r2 - 43'(dv_den[k]) : r2;
		end
	end

	// Square roots: r from s<<14 and sin Q3 from 2^60-q^2, in parallel.
	logic [30:0] q_d;
	logic [63:0] sq_arg, r_arg;
	assign q_d = dv_q[DivSteps];
	assign sq_arg = 64'(62'h1000000000000000 - 62'(q_d) * 62'(q_d));
	assign r_arg = 64'(dv_s[DivSteps]) << 14;

	// The side data is split over the two root lanes, one spare bit on top.
	logic [2*SqrtTagW-1:0] rt_tag_in, rt_tag_out;
	assign rt_tag_in = {1'b0, dv_tag[DivSteps], q_d};

	logic r_v, sq_v;
	logic [31:0] r_root, sq_root;
	lik_isqrt u_sqrt_r (
		.clk(clk), .arst_n(arst_n), .in_valid(dv_v[DivSteps]), .in_value(r_arg),
		.in_tag(rt_tag_in[2*SqrtTagW-1:SqrtTagW]), .out_valid(r_v), .out_root(r_root),
		.out_tag(rt_tag_out[2*SqrtTagW-1:SqrtTagW])
	);
	lik_isqrt u_sqrt_q (
		.clk(clk), .arst_n(arst_n), .in_valid(dv_v[DivSteps]), .in_value(sq_arg),
		.in_tag(rt_tag_in[SqrtTagW-1:0]), .out_valid(sq_v), .out_root(sq_root),
		.out_tag(rt_tag_out[SqrtTagW-1:0])
	);

	logic ok_t, nneg_t;
	logic signed [23:0] x_t, y_t, z_t;
	logic [LenW-1:0] l1_t, l2_t, l3_t;
	logic [30:0] q_t;
	assign {ok_t, nneg_t, x_t, y_t, z_t, l1_t, l2_t, l3_t, q_t} = rt_tag_out[DTagW+31-1:0];

	// Product stage: L3*sinQ3, L3*D split in partial products of 20x16.
	logic vld_p1;
	logic ok_p1, nneg_p1;
	logic signed [23:0] x_p1, y_p1, z_p1;
	logic [LenW-1:0] l1_p1, l2_p1;
	logic [31:0] r_p1, sq_p1;
	logic signed [31:0] d_p1;
	logic [35:0] ls_lo_p1, ls_hi_p1, ld_lo_p1, ld_hi_p1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_p1 <= 1'b0;
		else vld_p1 <= r_v;
	end
	always_ff @(posedge clk) begin
		ok_p1 <= ok_t;
		nneg_p1 <= nneg_t;
		x_p1 <= x_t;
		y_p1 <= y_t;
		z_p1 <= z_t;
		l1_p1 <= l1_t;
		l2_p1 <= l2_t;
		r_p1 <= r_root;
		sq_p1 <= sq_root;
		d_p1 <= nneg_t ? -32'(q_t) : 32'(q_t);
		ls_lo_p1 <= l3_t * sq_root[15:0];
		ls_hi_p1 <= l3_t * sq_root[31:16];
		ld_lo_p1 <= l3_t * q_t[15:0];
		ld_hi_p1 <= l3_t * 16'(q_t[30:16]);
	end

	logic [52:0] ls_c, ld_c;
	logic signed [95:0] den_x_c;
	assign ls_c = 53'(ls_lo_p1) + (53'(ls_hi_p1) << 16);
	assign ld_c = 53'(ld_lo_p1) + (53'(ld_hi_p1) << 16);
	assign den_x_c = (96'(l2_p1) << 30) + (nneg_p1 ? -96'(ld_c) : 96'(ld_c));

	// Five CORDIC vectoring units in parallel.
	logic cv [5];
	acc_t ca [5];
	lik_cordic u_c_hip0 (.clk(clk), .arst_n(arst_n), .in_valid(vld_p1),
		.in_y(-96'(y_p1)), .in_x(96'(x_p1)), .out_valid(cv[0]), .out_angle(ca[0]));
	lik_cordic u_c_hip1 (.clk(clk), .arst_n(arst_n), .in_valid(vld_p1),
		.in_y(96'(r_p1)), .in_x(-(96'(l1_p1) << 7)), .out_valid(cv[1]),
		.out_angle(ca[1]));
	lik_cordic u_c_q3 (.clk(clk), .arst_n(arst_n), .in_valid(vld_p1),
		.in_y(96'(sq_p1)), .in_x(96'(d_p1)), .out_valid(cv[2]), .out_angle(ca[2]));
	lik_cordic u_c_z (.clk(clk), .arst_n(arst_n), .in_valid(vld_p1),
		.in_y(96'(z_p1) <<< 7), .in_x(96'(r_p1)), .out_valid(cv[3]),
		.out_angle(ca[3]));
	lik_cordic u_c_k (.clk(clk), .arst_n(arst_n), .in_valid(vld_p1),
		.in_y(96'(ls_c)), .in_x(den_x_c), .out_valid(cv[4]), .out_angle(ca[4]));

	// Reachable flag rides alongside the CORDIC pipelines.
	localparam int CDepth = 3 + CordicSteps;
	logic [CDepth-1:0] ok_line_q;
	always_ff @(posedge clk) begin
		ok_line_q <= {ok_line_q[CDepth-2:0], ok_p1};
	end

	logic signed [21:0] hip_c, q2n_c, kn_c;
	assign hip_c = 22'(ca[0]) + 22'(ca[1]) + 22'sd8;
	assign q2n_c = 22'(ca[4]) - 22'(ca[3]) + 22'sd8;
	assign kn_c = 22'(PI_Q16) - 22'(ca[2]) + 22'sd8;

	logic ok_o;
	assign ok_o = ok_line_q[CDepth-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= cv[0];
	end
	always_ff @(posedge clk) begin
		reachable <= ok_o;
		hip_angle <= ok_o ? 16'(hip_c >>> 4) : '0;
		thigh_angle <= ok_o ? 16'(q2n_c >>> 4) : '0;
		knee_angle <= ok_o ? 16'(kn_c >>> 4) : '0;
	end

	logic unused_ok;
	assign unused_ok = sq_v ^ rt_tag_out[2*SqrtTagW-1] ^ (|cv[1]) ^ cv[2] ^ cv[3] ^ cv[4];

	`LIK_ASSERT(a_lanes_aligned, clk, arst_n,
		(cv[0] == cv[4]) && (cv[0] == cv[2]) && (r_v == sq_v), "pipeline lanes out of step")
	`LIK_ASSERT_NEXT(a_front_valid, clk, arst_n, acc_in, vld_s1, "accepted target lost")
	`LIK_ASSERT(a_zero_unreach, clk, arst_n,
		!done || reachable || (hip_angle == 0 && thigh_angle == 0 && knee_angle == 0),
		"unreachable result carries angles")
endmodule

// File: tb/testbench.sv
// ---------------------------------------------------------------------------
// Leg inverse kinematics testbench
// Drives foot targets under several leg geometries and checks every joint
// angle set against a bit-accurate fixed-point CORDIC and square-root model.
// ---------------------------------------------------------------------------
module testbench;
	import lik_pkg::*;

	typedef struct {
		bit                  is_cfg;
		logic [CfgIdxW-1:0]  idx;
		logic [LenW-1:0]     data;
		logic signed [23:0]  x;
		logic signed [23:0]  y;
		logic signed [23:0]  z;
	} op_t;

	typedef struct {
		logic signed [15:0] hip;
		logic signed [15:0] thigh;
		logic signed [15:0] knee;
		logic               ok;
	} angles_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [23:0] target_x = '0, target_y = '0, target_z = '0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [LenW-1:0] cfg_data = '0;
	logic busy, done, reachable;
	logic signed [15:0] hip_angle, thigh_angle, knee_angle;

	op_t pending_ops[$];
	angles_t expected_angles[$];
	longint leg_l1 = 0, leg_l2 = 256, leg_l3 = 256;
	int errors = 0, targets_sent = 0, results_seen = 0, unreachable_seen = 0;
	int phases_run = 0;

	localparam longint ATAN_Q16[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
		512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
	localparam longint HALF_TURN = 205887;

	leg_inverse_kinematics u_top (.*);

	initial forever #1 clk = ~clk;

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	// CORDIC vectoring atan2 in Q16 radians, operands normalized to [2^28, 2^29).
	function automatic longint cordic_atan2(longint y, longint x);
		longint acc = 0, m, xs, ys;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			acc = (y >= 0) ? HALF_TURN : -HALF_TURN;
			x = -x;
			y = -y;
		end
		m = abs64(x) > abs64(y) ? abs64(x) : abs64(y);
		while (m >= (64'sd1 << 29)) begin
			x = x >>> 1;
			y = y >>> 1;
			m = abs64(x) > abs64(y) ? abs64(x) : abs64(y);
		end
		while (m < (64'sd1 << 28)) begin
			x *= 2;
			y *= 2;
			m *= 2;
		end
		for (int i = 0; i < 17; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys;
				y -= xs;
				acc += ATAN_Q16[i];
			end else begin
				x -= ys;
				y += xs;
				acc -= ATAN_Q16[i];
			end
		end
		return acc;
	endfunction

	function automatic logic signed [15:0] round_q12(longint v);
		longint t;
		t = (v + 8) >>> 4;
		return t[15:0];
	endfunction

	function automatic angles_t solve_leg(longint x, longint y, longint z);
		angles_t a;
		longint s, n, den, an, r, q, rem, d, sq, hip, q2, q3;
		s = x * x + y * y - leg_l1 * leg_l1;
		n = s + z * z - leg_l2 * leg_l2 - leg_l3 * leg_l3;
		den = 2 * leg_l2 * leg_l3;
		an = abs64(n);
		a = '{hip: '0, thigh: '0, knee: '0, ok: 1'b0};
		if (s < 0 || den <= 0 || an > den) return a;
		r = int_sqrt(longint'(s) << 14);
		q = an / den;
		rem = an % den;
		for (int i = 0; i < 30; i++) begin
			q <<= 1;
			rem <<= 1;
			if (rem >= den) begin
				rem -= den;
				q |= 1;
			end
		end
		d = (n < 0) ? -q : q;
		sq = int_sqrt((64'd1 << 60) - q * q);
		hip = cordic_atan2(-y, x) + cordic_atan2(r, -leg_l1 * 128);
		q3 = cordic_atan2(sq, d);
		q2 = cordic_atan2(z * 128, r)
			- cordic_atan2(leg_l3 * sq, leg_l2 * (64'sd1 << 30) + leg_l3 * d);
		a.hip = round_q12(hip);
		a.thigh = round_q12(-q2);
		a.knee = round_q12(HALF_TURN - q3);
		a.ok = 1'b1;
		return a;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// Driver: holds start for a pending target until taken; register writes wait
	// until every transaction in flight has returned.
	always @(posedge clk) begin
		bit taken;
		bit we_next;
		taken = arst_n && start && !busy;
		we_next = 1'b0;
		if (taken) begin
			expected_angles.push_back(solve_leg(target_x, target_y, target_z));
			targets_sent++;
		end
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !taken) begin
			// hold the current target
		end else if (pending_ops.size() == 0) begin
			start <= 1'b0;
		end else if (pending_ops[0].is_cfg) begin
			start <= 1'b0;
			if (!taken && !cfg_we && expected_angles.size() == 0) begin
				we_next = 1'b1;
				cfg_index <= pending_ops[0].idx;
				cfg_data <= pending_ops[0].data;
				case (pending_ops[0].idx)
					REG_HIP_OFFSET: leg_l1 = pending_ops[0].data;
					REG_UPPER_LINK: leg_l2 = pending_ops[0].data;
					REG_LOWER_LINK: leg_l3 = pending_ops[0].data;
					default: ;
				endcase
				void'(pending_ops.pop_front());
			end
		end else if ((targets_sent < 700 || targets_sent > 1000)
				&& $urandom_range(99) < 7) begin
			start <= 1'b0;
		end else begin
			start <= 1'b1;
			target_x <= pending_ops[0].x;
			target_y <= pending_ops[0].y;
			target_z <= pending_ops[0].z;
			void'(pending_ops.pop_front());
		end
		cfg_we <= we_next;
	end

	// Monitor: every done cycle carries one result transaction.
	always @(posedge clk) begin
		angles_t e;
		if (arst_n && done) begin
			results_seen++;
			if (expected_angles.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				e = expected_angles.pop_front();
				if (!e.ok) unreachable_seen++;
				if (reachable !== e.ok) report_mismatch("reachable", reachable, e.ok);
				if (hip_angle !== e.hip) report_mismatch("hip_angle", hip_angle, e.hip);
				if (thigh_angle !== e.thigh)
					report_mismatch("thigh_angle", thigh_angle, e.thigh);
				if (knee_angle !== e.knee) report_mismatch("knee_angle", knee_angle, e.knee);
			end
		end
	end

	task automatic add_target(longint x, longint y, longint z);
		pending_ops.push_back('{is_cfg: 1'b0, idx: '0, data: '0, x: x, y: y, z: z});
	endtask

	task automatic add_write(logic [CfgIdxW-1:0] idx, longint v);
		pending_ops.push_back('{is_cfg: 1'b1, idx: idx, data: v, x: '0, y: '0, z: '0});
	endtask

	function automatic longint reach_coord(longint lim);
		return longint'($urandom_range(2 * lim)) - lim;
	endfunction

	initial begin
		longint geo[8][3] = '{'{0, 256, 256}, '{12800, 25600, 25600},
			'{2560, 38400, 12800}, '{1048575, 1048575, 1048575}, '{0, 1, 1},
			'{5000, 0, 3000}, '{100, 1048575, 1}, '{0, 512, 256}};
		longint lim;
		// Directed targets under the reset geometry.
		add_target(0, 0, 0);
		add_target(512, 0, 0);
		add_target(-512, 0, 0);
		add_target(0, 512, 0);
		add_target(0, -512, 0);
		add_target(0, 0, 512);
		add_target(0, 0, -512);
		add_target(300, 200, -100);
		add_target(-300, -200, 100);
		add_target(8388607, 8388607, 8388607);
		add_target(-8388608, -8388608, -8388608);
		add_target(8388607, -8388608, 0);
		add_target(362, 362, 0);
		add_target(1, 0, 0);
		add_target(0, 0, 1);
		add_target(-1, -1, -1);
		add_write(2'd3, 20'hFFFFF);
		add_target(256, 256, 0);
		for (int p = 0; p < 8; p++) begin
			add_write(REG_HIP_OFFSET, geo[p][0]);
			add_write(REG_UPPER_LINK, geo[p][1]);
			add_write(REG_LOWER_LINK, geo[p][2]);
			lim = geo[p][0] + geo[p][1] + geo[p][2] + 2;
			if (lim > 8388607) lim = 8388607;
			if (p == 3) begin
				add_target(1048575, 0, 0);
				add_target(-1048575, 0, 0);
				add_target(1048575, 0, 1048575);
			end
			for (int k = 0; k < 215; k++) begin
				if ($urandom_range(99) < 70)
					add_target(reach_coord(lim), reach_coord(lim), reach_coord(lim));
				else
					add_target(24'($urandom), 24'($urandom), 24'($urandom));
			end
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_ops.size() != 0 || start || expected_angles.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("Ran %0d foot targets over 8 leg geometries; %0d results, %0d unreachable.",
			targets_sent, results_seen, unreachable_seen);
		if (errors == 0 && expected_angles.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#500000;
		$display("timeout with %0d results outstanding", expected_angles.size());
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// File: sim.f
+incdir+rtl
rtl/lik_pkg.sv
rtl/lik_isqrt.sv
rtl/lik_cordic.sv
rtl/leg_inverse_kinematics.sv
tb/testbench.sv
